/* sv/rk4_pkg.sv */
// ----------------------------------------------------------------------------
// RK4 plant step package
// Shared widths, constants, controller states and datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package rk4_pkg;

    // Field widths
    localparam int X_W     = 32;   // plant states and output
    localparam int U_W     = 27;   // drive input
    localparam int COEF_W  = 27;   // numerator coefficients
    localparam int DT_W    = 16;   // step size, unsigned Q0.16
    localparam int AREA_W  = 48;   // undershoot area, unsigned

    // Step size fraction bits
    localparam int DT_BITS = 16;

    // Shared multiplier: 35 x 27 signed
    localparam int MA_W    = 35;
    localparam int MB_W    = 27;
    localparam int PROD_W  = MA_W + MB_W;

    // Internal widths
    localparam int ACC_W   = 60;   // b0*x1 + b1*x2, also the saturation input
    localparam int KS_W    = 35;   // k1 + 2*k2 + 2*k3 + k4
    localparam int D_W     = 36;   // -6*x1 - 5*x2 + u
    localparam int ST_W    = 49;   // k*dt
    localparam int FIN_W   = 52;   // ksum*dt + rounding offset
    localparam int WP_W    = 38;   // biased dividend
    localparam int QW      = 36;   // biased quotient

    // Digit-serial divide by six
    localparam int DIV_D     = 6;
    localparam int DIG_W     = 8;
    localparam int REM_W     = 3;
    localparam int NUM_W     = REM_W + DIG_W;
    localparam int DIV_STEPS = 5;
    localparam int DIV_W     = DIV_STEPS * DIG_W;
    localparam int REC_M     = 2731;  // ceil(2^14 / 6)
    localparam int REC_SH    = 14;
    localparam int REC_PW    = 23;

    // Runge-Kutta stage indexes
    localparam int LAST_STAGE = 3;

    // Register map
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_STEP_SIZE  = 2'd0;
    localparam logic [1:0] REG_COEFF_CONS = 2'd1;
    localparam logic [1:0] REG_COEFF_SLOP = 2'd2;

    localparam logic [DT_W-1:0]          STEP_SIZE_RST  = 16'd131;
    localparam logic signed [COEF_W-1:0] COEFF_CONS_RST = 27'sd393216;
    localparam logic signed [COEF_W-1:0] COEFF_SLOP_RST = -27'sd393216;

    typedef logic signed [U_W-1:0]  t_drive;
    typedef logic signed [X_W-1:0]  t_plant;
    typedef logic [AREA_W-1:0]      t_area;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_Y_MUL0,
        ST_Y_MUL1,
        ST_Y_SUM,
        ST_Y_RND,
        ST_A_MUL,
        ST_A_ADD,
        ST_K,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_F_MUL1,
        ST_F_MUL2,
        ST_F_W2,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_B0X1,
        MUL_B1X2,
        MUL_NEGY,
        MUL_K1,
        MUL_K2,
        MUL_KS1,
        MUL_KS2
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        KS_LOAD,
        KS_ADD1,
        KS_ADD2
    } t_ks_op;

    typedef struct packed {
        logic     load;      // capture drive, seed stage states
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     y_load;
        logic     area_upd;
        logic     k_load;
        t_ks_op   ks_op;
        logic     s1_upd;
        logic     s2_upd;
        logic     half;      // stage uses dt/2
        logic     w1_load;
        logic     w2_load;
        logic     div_step;
        logic     commit;    // update state, load result register
    } t_dp_cmd;

endpackage

`default_nettype wire

/* sv/rk4_if.sv */
// ----------------------------------------------------------------------------
// RK4 plant step channels
// Valid/ready channels for the drive input and the plant result.
// ----------------------------------------------------------------------------
`default_nettype none

interface rk4_drive_if;
    logic           valid;
    logic           ready;
    rk4_pkg::t_drive drive_input;

    modport source (output valid, output drive_input, input ready);
    modport sink   (input valid, input drive_input, output ready);
endinterface

interface rk4_result_if;
    logic           valid;
    logic           ready;
    rk4_pkg::t_plant plant_output;
    rk4_pkg::t_area  undershoot_total;

    modport source (output valid, output plant_output, output undershoot_total, input ready);
    modport sink   (input valid, input plant_output, input undershoot_total, output ready);
endinterface

`default_nettype wire

/* sv/rk4_datapath.sv */
// ----------------------------------------------------------------------------
// RK4 plant step datapath
// Shared multiplier, state registers, stage update and divide-by-six unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire rk4_pkg::t_dp_cmd                       i_cmd,
    input  wire logic [rk4_pkg::DT_W-1:0]               i_step_size,
    input  wire logic signed [rk4_pkg::COEF_W-1:0]      i_zero_coeff_const,
    input  wire logic signed [rk4_pkg::COEF_W-1:0]      i_zero_coeff_slope,
    input  wire logic signed [rk4_pkg::U_W-1:0]         i_drive_input,
    output logic signed [rk4_pkg::X_W-1:0]              o_plant_output,
    output logic [rk4_pkg::AREA_W-1:0]                  o_undershoot_total
);

    localparam int X_W    = rk4_pkg::X_W;
    localparam int ACC_W  = rk4_pkg::ACC_W;
    localparam int MA_W   = rk4_pkg::MA_W;
    localparam int MB_W   = rk4_pkg::MB_W;
    localparam int PROD_W = rk4_pkg::PROD_W;
    localparam int KS_W   = rk4_pkg::KS_W;
    localparam int D_W    = rk4_pkg::D_W;
    localparam int ST_W   = rk4_pkg::ST_W;
    localparam int FIN_W  = rk4_pkg::FIN_W;
    localparam int WP_W   = rk4_pkg::WP_W;
    localparam int QW     = rk4_pkg::QW;
    localparam int DIV_W  = rk4_pkg::DIV_W;
    localparam int DIG_W  = rk4_pkg::DIG_W;
    localparam int REM_W  = rk4_pkg::REM_W;
    localparam int NUM_W  = rk4_pkg::NUM_W;
    localparam int AREA_W = rk4_pkg::AREA_W;
    localparam int DT_BITS = rk4_pkg::DT_BITS;
    localparam int AR_W   = AREA_W + 1;

    localparam logic signed [ACC_W-1:0] Y_HALF    = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ST_W-1:0]  ST_HALF_H = ST_W'(1) <<< DT_BITS;
    localparam logic signed [ST_W-1:0]  ST_HALF_F = ST_W'(1) <<< (DT_BITS - 1);
    localparam logic [AR_W-1:0]         AR_HALF   = AR_W'(1) << (DT_BITS - 1);
    localparam logic signed [FIN_W-1:0] FIN_OFS   = FIN_W'(3) <<< DT_BITS;
    localparam logic signed [FIN_W-1:0] DIV_BIAS  = FIN_W'(3) <<< (WP_W - 2);
    localparam logic signed [QW:0]      Q_BIAS    = (QW + 1)'(1) <<< (QW - 1);
    localparam logic signed [X_W-1:0]   X_MAX     = {1'b0, {(X_W - 1){1'b1}}};
    localparam logic signed [X_W-1:0]   X_MIN     = {1'b1, {(X_W - 1){1'b0}}};

    function automatic logic signed [X_W-1:0] sat_x(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(X_MAX)) begin
            return X_MAX;
        end else if (v < ACC_W'(X_MIN)) begin
            return X_MIN;
        end
        return v[X_W-1:0];
    endfunction

    // One radix-256 digit of a divide by six: returns {remainder, digit}
    function automatic logic [NUM_W-1:0] div_digit(input logic [NUM_W-1:0] n);
        logic [rk4_pkg::REC_PW-1:0] p;
        logic [DIG_W-1:0]           qd;
        logic [NUM_W-1:0]           r;
        p  = rk4_pkg::REC_PW'(n) * rk4_pkg::REC_PW'(rk4_pkg::REC_M);
        qd = p[rk4_pkg::REC_SH +: DIG_W];
        r  = n - NUM_W'(qd) * NUM_W'(rk4_pkg::DIV_D);
        return {r[REM_W-1:0], qd};
    endfunction

    // State and working registers
    logic signed [X_W-1:0]    r_x1, r_x2;
    logic [AREA_W-1:0]        r_area;
    logic signed [rk4_pkg::U_W-1:0] r_u;
    logic signed [X_W-1:0]    r_s1, r_s2;
    logic signed [X_W-1:0]    r_k1, r_k2;
    logic signed [KS_W-1:0]   r_ks1, r_ks2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [X_W-1:0]    r_y;
    logic [DIV_W-1:0]         r_dv1, r_dv2;
    logic [REM_W-1:0]         r_rem1, r_rem2;
    logic signed [X_W-1:0]    r_out_y;
    logic [AREA_W-1:0]        r_out_area;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MB_W-1:0]   dt_s;
    logic signed [ACC_W-1:0]  y_rnd;
    logic [AR_W-1:0]          area_rnd;
    logic [AR_W-1:0]          area_sum;
    logic signed [D_W-1:0]    d_sum;
    logic signed [X_W-1:0]    k2_next;
    logic signed [ST_W-1:0]   st_p;
    logic signed [ST_W-1:0]   st_rnd;
    logic signed [FIN_W-1:0]  fin_v;
    logic signed [FIN_W-1:0]  fin_w;
    logic [NUM_W-1:0]         dig1, dig2;
    logic signed [QW:0]       q1, q2;

    assign dt_s = signed'(MB_W'(i_step_size));

    // Operand select for the shared multiplier
    always_comb begin
        unique case (i_cmd.mul_sel)
            rk4_pkg::MUL_IDLE: begin
                mul_a = '0;
                mul_b = '0;
            end
            rk4_pkg::MUL_B0X1: begin
                mul_a = MA_W'(r_x1);
                mul_b = i_zero_coeff_const;
            end
            rk4_pkg::MUL_B1X2: begin
                mul_a = MA_W'(r_x2);
                mul_b = i_zero_coeff_slope;
            end
            rk4_pkg::MUL_NEGY: begin
                mul_a = -(MA_W'(r_y));
                mul_b = dt_s;
            end
            rk4_pkg::MUL_K1: begin
                mul_a = MA_W'(r_k1);
                mul_b = dt_s;
            end
            rk4_pkg::MUL_K2: begin
                mul_a = MA_W'(r_k2);
                mul_b = dt_s;
            end
            rk4_pkg::MUL_KS1: begin
                mul_a = r_ks1;
                mul_b = dt_s;
            end
            rk4_pkg::MUL_KS2: begin
                mul_a = r_ks2;
                mul_b = dt_s;
            end
        endcase
    end

    // Output rounding, area increment, derivative, stage rounding, final quotient
    always_comb begin
        y_rnd    = (r_acc + Y_HALF) >>> FRAC_BITS;
        area_rnd = (AR_W'(r_prod[AREA_W-1:0]) + AR_HALF) >> DT_BITS;
        area_sum = {1'b0, r_area} + area_rnd;
        d_sum    = -(D_W'(r_s1) <<< 2) - (D_W'(r_s1) <<< 1)
                   - (D_W'(r_s2) <<< 2) - D_W'(r_s2) + D_W'(r_u);
        k2_next  = sat_x(ACC_W'(d_sum));
        st_p     = signed'(r_prod[ST_W-1:0]);
        st_rnd   = i_cmd.half ? ((st_p + ST_HALF_H) >>> (DT_BITS + 1))
                              : ((st_p + ST_HALF_F) >>> DT_BITS);
        fin_v    = signed'(r_prod[FIN_W-1:0]) + FIN_OFS;
        fin_w    = (fin_v >>> DT_BITS) + DIV_BIAS;
        dig1     = div_digit({r_rem1, r_dv1[DIV_W-1 -: DIG_W]});
        dig2     = div_digit({r_rem2, r_dv2[DIV_W-1 -: DIG_W]});
        q1       = signed'({1'b0, r_dv1[QW-1:0]}) - Q_BIAS;
        q2       = signed'({1'b0, r_dv2[QW-1:0]}) - Q_BIAS;
    end

    // Architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1   <= '0;
            r_x2   <= '0;
            r_area <= '0;
        end else begin
            if (i_cmd.area_upd && r_y[X_W-1]) begin
                r_area <= area_sum[AREA_W] ? {AREA_W{1'b1}} : area_sum[AREA_W-1:0];
            end
            if (i_cmd.commit) begin
                r_x1 <= sat_x(ACC_W'(r_x1) + ACC_W'(q1));
                r_x2 <= sat_x(ACC_W'(r_x2) + ACC_W'(q2));
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (i_cmd.load) begin
            r_u  <= i_drive_input;
            r_s1 <= r_x1;
            r_s2 <= r_x2;
        end

        unique case (i_cmd.acc_op)
            rk4_pkg::ACC_LOAD: r_acc <= signed'(r_prod[ACC_W-1:0]);
            rk4_pkg::ACC_ADD:  r_acc <= r_acc + signed'(r_prod[ACC_W-1:0]);
            default:           r_acc <= r_acc;
        endcase

        if (i_cmd.y_load) begin
            r_y <= sat_x(y_rnd);
        end

        if (i_cmd.k_load) begin
            r_k1 <= r_s2;
            r_k2 <= k2_next;
            unique case (i_cmd.ks_op)
                rk4_pkg::KS_LOAD: begin
                    r_ks1 <= KS_W'(r_s2);
                    r_ks2 <= KS_W'(k2_next);
                end
                rk4_pkg::KS_ADD1: begin
                    r_ks1 <= r_ks1 + KS_W'(r_s2);
                    r_ks2 <= r_ks2 + KS_W'(k2_next);
                end
                rk4_pkg::KS_ADD2: begin
                    r_ks1 <= r_ks1 + (KS_W'(r_s2) <<< 1);
                    r_ks2 <= r_ks2 + (KS_W'(k2_next) <<< 1);
                end
                default: begin
                    r_ks1 <= r_ks1;
                    r_ks2 <= r_ks2;
                end
            endcase
        end

        if (i_cmd.s1_upd) begin
            r_s1 <= sat_x(ACC_W'(r_x1) + ACC_W'(st_rnd));
        end
        if (i_cmd.s2_upd) begin
            r_s2 <= sat_x(ACC_W'(r_x2) + ACC_W'(st_rnd));
        end

        // Bias the dividend positive so the divide works on unsigned digits
        if (i_cmd.w1_load) begin
            r_dv1  <= DIV_W'(fin_w[WP_W-1:0]);
            r_rem1 <= '0;
        end else if (i_cmd.div_step) begin
            r_dv1  <= {r_dv1[DIV_W-DIG_W-1:0], dig1[DIG_W-1:0]};
            r_rem1 <= dig1[NUM_W-1:DIG_W];
        end
        if (i_cmd.w2_load) begin
            r_dv2  <= DIV_W'(fin_w[WP_W-1:0]);
            r_rem2 <= '0;
        end else if (i_cmd.div_step) begin
            r_dv2  <= {r_dv2[DIV_W-DIG_W-1:0], dig2[DIG_W-1:0]};
            r_rem2 <= dig2[NUM_W-1:DIG_W];
        end

        if (i_cmd.commit) begin
            r_out_y    <= r_y;
            r_out_area <= r_area;
        end
    end

    assign o_plant_output     = r_out_y;
    assign o_undershoot_total = r_out_area;

endmodule

`default_nettype wire

/* sv/rk4_ctrl.sv */
// ----------------------------------------------------------------------------
// RK4 plant step controller
// Sequences the datapath through output, area, four stages and final update.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output rk4_pkg::t_dp_cmd      o_cmd
);

    rk4_pkg::t_state r_state, n_state;
    logic [2:0]      r_cnt, n_cnt;
    logic            r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rk4_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_sel = rk4_pkg::MUL_IDLE;
        o_cmd.acc_op  = rk4_pkg::ACC_HOLD;
        o_cmd.ks_op   = rk4_pkg::KS_LOAD;

        unique case (r_state)
            rk4_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = rk4_pkg::ST_Y_MUL0;
                end
            end
            rk4_pkg::ST_Y_MUL0: begin
                o_cmd.mul_sel = rk4_pkg::MUL_B0X1;
                n_state       = rk4_pkg::ST_Y_MUL1;
            end
            rk4_pkg::ST_Y_MUL1: begin
                o_cmd.mul_sel = rk4_pkg::MUL_B1X2;
                o_cmd.acc_op  = rk4_pkg::ACC_LOAD;
                n_state       = rk4_pkg::ST_Y_SUM;
            end
            rk4_pkg::ST_Y_SUM: begin
                o_cmd.acc_op = rk4_pkg::ACC_ADD;
                n_state      = rk4_pkg::ST_Y_RND;
            end
            rk4_pkg::ST_Y_RND: begin
                o_cmd.y_load = 1'b1;
                n_state      = rk4_pkg::ST_A_MUL;
            end
            rk4_pkg::ST_A_MUL: begin
                o_cmd.mul_sel = rk4_pkg::MUL_NEGY;
                n_state       = rk4_pkg::ST_A_ADD;
            end
            rk4_pkg::ST_A_ADD: begin
                o_cmd.area_upd = 1'b1;
                n_state        = rk4_pkg::ST_K;
            end
            rk4_pkg::ST_K: begin
                o_cmd.k_load = 1'b1;
                priority if (r_cnt == '0) begin
                    o_cmd.ks_op = rk4_pkg::KS_LOAD;
                end else if (r_cnt == 3'(rk4_pkg::LAST_STAGE)) begin
                    o_cmd.ks_op = rk4_pkg::KS_ADD1;
                end else begin
                    o_cmd.ks_op = rk4_pkg::KS_ADD2;
                end
                n_state = (r_cnt == 3'(rk4_pkg::LAST_STAGE)) ? rk4_pkg::ST_F_MUL1
                                                              : rk4_pkg::ST_M1;
            end
            rk4_pkg::ST_M1: begin
                o_cmd.mul_sel = rk4_pkg::MUL_K1;
                n_state       = rk4_pkg::ST_M2;
            end
            rk4_pkg::ST_M2: begin
                o_cmd.mul_sel = rk4_pkg::MUL_K2;
                o_cmd.s1_upd  = 1'b1;
                o_cmd.half    = (r_cnt < 3'(rk4_pkg::LAST_STAGE - 1));
                n_state       = rk4_pkg::ST_M3;
            end
            rk4_pkg::ST_M3: begin
                o_cmd.s2_upd = 1'b1;
                o_cmd.half   = (r_cnt < 3'(rk4_pkg::LAST_STAGE - 1));
                n_cnt        = r_cnt + 3'd1;
                n_state      = rk4_pkg::ST_K;
            end
            rk4_pkg::ST_F_MUL1: begin
                o_cmd.mul_sel = rk4_pkg::MUL_KS1;
                n_state       = rk4_pkg::ST_F_MUL2;
            end
            rk4_pkg::ST_F_MUL2: begin
                o_cmd.mul_sel = rk4_pkg::MUL_KS2;
                o_cmd.w1_load = 1'b1;
                n_state       = rk4_pkg::ST_F_W2;
            end
            rk4_pkg::ST_F_W2: begin
                o_cmd.w2_load = 1'b1;
                n_cnt         = '0;
                n_state       = rk4_pkg::ST_DIV;
            end
            rk4_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 3'd1;
                if (r_cnt == 3'(rk4_pkg::DIV_STEPS - 1)) begin
                    n_state = rk4_pkg::ST_DONE;
                end
            end
            rk4_pkg::ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = rk4_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_vld || i_out_ready))
        else $error("result register overwritten while still pending");

    a_stage_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rk4_pkg::ST_K) |-> (r_cnt <= 3'(rk4_pkg::LAST_STAGE)))
        else $error("stage counter out of range");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rk4_pkg::ST_DIV) |-> (r_cnt < 3'(rk4_pkg::DIV_STEPS)))
        else $error("divide step counter out of range");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == rk4_pkg::ST_DONE))
        else $error("result raised outside the final step");

endmodule

`default_nettype wire

/* sv/rk4_second_order_plant_step.sv */
// ----------------------------------------------------------------------------
// RK4 second-order plant step
// Fixed-point real-time emulator of (b1*s + b0) / (s^2 + 5s + 6).
// ----------------------------------------------------------------------------
// Each transfer on i_drive is one time tick with drive u. The block reports
// y = b0*x1 + b1*x2 from the state before the tick together with the running
// undershoot area (the sum of -y*dt over ticks with y < 0, including this
// one), then advances x1, x2 by one classic fourth-order Runge-Kutta step of
// size dt. Between its input transfer and the next point where the block can
// take input, one shared 35x27 multiplier serves eleven products in sequence
// (two for y, one for the area, two per stage for three stages, two for the
// final update), and the final divide by six runs digit-serially, eight bits
// per cycle, five digits for each of the two quotients. A finished
// result sits in an output register, so the next item is taken while that
// result waits; the block only holds at its last cycle if the previous
// result is still not taken. Registers (APB, 32-bit data): step_size at
// 0x0, zero_coeff_const at 0x4, zero_coeff_slope at 0x8; write them only
// while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4_second_order_plant_step #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    rk4_drive_if.sink                         i_drive,
    rk4_result_if.source                      o_result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rk4_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // Configuration registers
    logic [rk4_pkg::DT_W-1:0]          r_step_size;
    logic signed [rk4_pkg::COEF_W-1:0] r_coeff_cons;
    logic signed [rk4_pkg::COEF_W-1:0] r_coeff_slop;

    logic [1:0]       reg_idx;
    logic             cfg_wr;
    rk4_pkg::t_dp_cmd dp_cmd;
    logic             in_ready;
    logic             out_valid;

    // Register index from the word address; low byte bits are ignored
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write on the access cycle; unknown addresses drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size  <= rk4_pkg::STEP_SIZE_RST;
            r_coeff_cons <= rk4_pkg::COEFF_CONS_RST;
            r_coeff_slop <= rk4_pkg::COEFF_SLOP_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                rk4_pkg::REG_STEP_SIZE:  r_step_size  <= pwdata[rk4_pkg::DT_W-1:0];
                rk4_pkg::REG_COEFF_CONS: r_coeff_cons <= signed'(pwdata[rk4_pkg::COEF_W-1:0]);
                rk4_pkg::REG_COEFF_SLOP: r_coeff_slop <= signed'(pwdata[rk4_pkg::COEF_W-1:0]);
                default: ;
            endcase
        end
    end

    // Read back; coefficients come back sign-extended
    always_comb begin
        unique case (reg_idx)
            rk4_pkg::REG_STEP_SIZE:  prdata = 32'(r_step_size);
            rk4_pkg::REG_COEFF_CONS: prdata = 32'(r_coeff_cons);
            rk4_pkg::REG_COEFF_SLOP: prdata = 32'(r_coeff_slop);
            default:                 prdata = '0;
        endcase
    end

    // Sequence the tick: output, area, four derivative stages, final update
    rk4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_drive.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (dp_cmd)
    );

    // Hold state, share the multiplier and divide by six
    rk4_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .i_step_size        (r_step_size),
        .i_zero_coeff_const (r_coeff_cons),
        .i_zero_coeff_slope (r_coeff_slop),
        .i_drive_input      (i_drive.drive_input),
        .o_plant_output     (o_result.plant_output),
        .o_undershoot_total (o_result.undershoot_total)
    );

    assign i_drive.ready  = in_ready;
    assign o_result.valid = out_valid;

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// RK4 second-order plant step testbench
// Drives time ticks into the plant emulator over its valid/ready channel,
// programs dt and the numerator coefficients over APB between phases, and
// checks every result against a cycle-free fixed-point predictor of the plant.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rk4_pkg::*;

    localparam int     FRAC_BITS     = 16;
    localparam int     CYCLE_LIMIT   = 600000;
    localparam int     RANDOM_ITEMS  = 225;  // per configuration phase
    localparam int     QUIET_ITEMS   = 130;
    localparam int     PARK_CYCLES   = 300;
    localparam int     TAIL_CYCLES   = 60;
    localparam longint AREA_LIMIT    = (longint'(1) <<< AREA_W) - 1;

    // Register index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam t_drive DRIVE_MAX = {1'b0, {(U_W-1){1'b1}}};
    localparam t_drive DRIVE_MIN = {1'b1, {(U_W-1){1'b0}}};

    typedef logic signed [COEF_W-1:0] coeff_t;
    localparam coeff_t COEFF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam coeff_t COEFF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct {
        t_plant y;
        t_area  area;
    } tick_report_t;

    // ------------------------------------------------------------------------
    // Clock, reset, channels, APB
    // ------------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    rk4_drive_if  drive_ch ();
    rk4_result_if result_ch ();

    rk4_second_order_plant_step #(
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_drive  (drive_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Plant predictor: its own copy of the registers and the state
    // ------------------------------------------------------------------------
    logic [DT_W-1:0] cfg_dt;
    coeff_t          cfg_b0;
    coeff_t          cfg_b1;
    t_plant          plant_pos;
    t_plant          plant_vel;
    t_area           plant_area;

    tick_report_t    pending_reports[$];

    int  error_count   = 0;
    int  ticks_sent    = 0;
    int  results_seen  = 0;
    int  neg_ticks     = 0;
    int  phases_run    = 0;
    int  cycle_count   = 0;
    int  park_request  = 0;
    bit  src_idle_en   = 1'b1;
    bit  sink_idle_en  = 1'b1;

    function automatic longint round_half_up(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic t_plant clamp_plant(longint v);
        if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -longint'(64'sd2147483648)) return 32'sh80000000;
        return t_plant'(v);
    endfunction

    // x2' = -6*x1 - 5*x2 + u, saturated
    function automatic t_plant plant_accel(t_plant p, t_plant v, t_drive u);
        return clamp_plant(-6 * longint'(p) - 5 * longint'(v) + longint'(u));
    endfunction

    // Intermediate point x + k*h; sh = 17 for h = dt/2, 16 for h = dt
    function automatic t_plant stage_point(t_plant x, t_plant k, int sh);
        return clamp_plant(longint'(x) + round_half_up(longint'(k) * longint'(cfg_dt), sh));
    endfunction

    // x + round(ksum*dt / (6*2^16)), ties up, floor after the bias
    function automatic t_plant rk4_advance(t_plant x, longint ksum);
        longint den;
        longint num;
        longint q;
        den = 6 * (longint'(1) <<< DT_BITS);
        num = ksum * longint'(cfg_dt) + 3 * (longint'(1) <<< DT_BITS);
        q   = num / den;
        if (num < 0 && q * den != num) q = q - 1;
        return clamp_plant(longint'(x) + q);
    endfunction

    task automatic reset_plant_model();
        cfg_dt     = STEP_SIZE_RST;
        cfg_b0     = COEFF_CONS_RST;
        cfg_b1     = COEFF_SLOP_RST;
        plant_pos  = '0;
        plant_vel  = '0;
        plant_area = '0;
    endtask

    // Work out the report for one accepted tick, then advance the state.
    task automatic predict_plant_tick(t_drive u);
        longint       acc;
        longint       area_next;
        t_plant       y;
        t_plant       a1, a2, b1, b2, c1, c2, e1, e2, s1, s2;
        t_plant       pos_next, vel_next;
        tick_report_t rep;

        acc = longint'(cfg_b0) * longint'(plant_pos) + longint'(cfg_b1) * longint'(plant_vel);
        y   = clamp_plant(round_half_up(acc, FRAC_BITS));
        if (y < 0) begin
            neg_ticks++;
            area_next = longint'(plant_area)
                      + round_half_up(-longint'(y) * longint'(cfg_dt), DT_BITS);
            plant_area = (area_next > AREA_LIMIT) ? '1 : t_area'(area_next);
        end

        a1 = plant_vel;
        a2 = plant_accel(plant_pos, plant_vel, u);
        s1 = stage_point(plant_pos, a1, DT_BITS + 1);
        s2 = stage_point(plant_vel, a2, DT_BITS + 1);
        b1 = s2;
        b2 = plant_accel(s1, s2, u);
        s1 = stage_point(plant_pos, b1, DT_BITS + 1);
        s2 = stage_point(plant_vel, b2, DT_BITS + 1);
        c1 = s2;
        c2 = plant_accel(s1, s2, u);
        s1 = stage_point(plant_pos, c1, DT_BITS);
        s2 = stage_point(plant_vel, c2, DT_BITS);
        e1 = s2;
        e2 = plant_accel(s1, s2, u);

        pos_next = rk4_advance(plant_pos, longint'(a1) + 2 * longint'(b1)
                                        + 2 * longint'(c1) + longint'(e1));
        vel_next = rk4_advance(plant_vel, longint'(a2) + 2 * longint'(b2)
                                        + 2 * longint'(c2) + longint'(e2));
        plant_pos = pos_next;
        plant_vel = vel_next;

        rep.y    = y;
        rep.area = plant_area;
        pending_reports.push_back(rep);
    endtask

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch, and count it
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Drive side: one tick per transfer, random gaps when enabled
    // ------------------------------------------------------------------------
    task automatic send_tick(t_drive u);
        int gap;
        gap = (src_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            // Drop valid for a burst, then offer the tick
            drive_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        drive_ch.valid       = 1'b1;
        drive_ch.drive_input = u;
        @(posedge i_clk);
        while (!drive_ch.ready) @(posedge i_clk);
        // Transfer happened at this edge: predict against current registers
        predict_plant_tick(u);
        ticks_sent++;
    endtask

    // Mostly moderate drives that keep the plant in its useful range, with
    // full-scale noise and exact extremes mixed in.
    function automatic t_drive pick_drive();
        case ($urandom_range(0, 7))
            0, 1:    return t_drive'($urandom);
            2:       return $urandom_range(0, 1) ? DRIVE_MAX : DRIVE_MIN;
            default: return t_drive'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    // Stop offering, then hold until every predicted report has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        drive_ch.valid = 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] reg_addr(logic [1:0] idx);
        return {idx, 2'b00};
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = reg_addr(idx);
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // Register takes the field bits only; upper bits are dropped
        case (idx)
            REG_STEP_SIZE:  cfg_dt = data[DT_W-1:0];
            REG_COEFF_CONS: cfg_b0 = data[COEF_W-1:0];
            REG_COEFF_SLOP: cfg_b1 = data[COEF_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apb_read(logic [1:0] idx, output logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = reg_addr(idx);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Program all three registers with junk above the fields, and poke the
    // unused index, which must change nothing.
    task automatic set_plant_config(logic [DT_W-1:0] dt, coeff_t b0, coeff_t b1);
        apb_write(REG_STEP_SIZE,  {16'($urandom), dt});
        apb_write(REG_COEFF_CONS, {5'($urandom), b0});
        apb_write(REG_COEFF_SLOP, {5'($urandom), b1});
        apb_write(REG_UNUSED,     $urandom);
        phases_run++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Ticks at the reset settings: zero, both drive extremes, minus one and two alternating bit patterns.
    task automatic test_reset_defaults();
        send_tick('0);
        send_tick(DRIVE_MAX);
        send_tick(DRIVE_MAX);
        send_tick(DRIVE_MIN);
        send_tick(t_drive'(-1));
        send_tick(t_drive'(27'h2AAAAAA));
        send_tick(t_drive'(27'h1555555));
        wait_idle();
    endtask

    // Write each register with random contents, then read all back.
    task automatic test_register_map();
        logic [31:0] rd;
        set_plant_config(16'($urandom), coeff_t'($urandom), coeff_t'($urandom));
        apb_read(REG_STEP_SIZE, rd);
        if (rd[DT_W-1:0] !== cfg_dt)
            flag_mismatch($sformatf("step_size read %h, want %h", rd[DT_W-1:0], cfg_dt));
        apb_read(REG_COEFF_CONS, rd);
        if (rd[COEF_W-1:0] !== cfg_b0)
            flag_mismatch($sformatf("zero_coeff_const read %h, want %h",
                                    rd[COEF_W-1:0], cfg_b0));
        apb_read(REG_COEFF_SLOP, rd);
        if (rd[COEF_W-1:0] !== cfg_b1)
            flag_mismatch($sformatf("zero_coeff_slope read %h, want %h",
                                    rd[COEF_W-1:0], cfg_b1));
    endtask

    // dt = 0: the state and the area freeze, y is still reported.
    task automatic test_zero_step();
        set_plant_config('0, COEFF_CONS_RST, COEFF_SLOP_RST);
        send_tick(DRIVE_MAX);
        send_tick(DRIVE_MIN);
        send_tick('0);
        send_tick(t_drive'(12345));
        wait_idle();
    endtask

    // Largest dt and coefficient extremes push y into saturation.
    task automatic test_saturation_extremes();
        set_plant_config('1, COEFF_MAX, COEFF_MIN);
        repeat (4) send_tick(DRIVE_MAX);
        repeat (3) send_tick(DRIVE_MIN);
        wait_idle();
    endtask

    // Park the result side while ticks keep coming, so the block fills its
    // output register and stalls the drive channel.
    task automatic test_backpressure();
        set_plant_config(STEP_SIZE_RST, COEFF_CONS_RST, COEFF_SLOP_RST);
        park_request = PARK_CYCLES;
        repeat (12) send_tick(pick_drive());
        wait_idle();
    endtask

    // Random ticks across a set of settings that includes the extremes.
    task automatic test_random_phases();
        int              p;
        logic [DT_W-1:0] dt;
        coeff_t          b0;
        coeff_t          b1;
        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin dt = STEP_SIZE_RST; b0 = COEFF_CONS_RST; b1 = COEFF_SLOP_RST; end
                1: begin dt = '1;            b0 = COEFF_MAX;      b1 = COEFF_MIN;      end
                2: begin dt = 16'd1;         b0 = COEFF_MIN;      b1 = COEFF_MAX;      end
                3: begin dt = '0;            b0 = coeff_t'($urandom); b1 = coeff_t'($urandom); end
                4: begin dt = 16'($urandom); b0 = coeff_t'($urandom); b1 = coeff_t'($urandom); end
                5: begin dt = 16'd2000;      b0 = '0;             b1 = 27'sd65536;     end
                6: begin
                    dt = 16'($urandom_range(1, 4000));
                    b0 = coeff_t'($urandom);
                    b1 = coeff_t'($urandom);
                end
                default: begin dt = STEP_SIZE_RST; b0 = COEFF_MAX; b1 = '0; end
            endcase
            // Vary which side idles so some phases run with one side not idling
            src_idle_en  = (p % 3) != 1;
            sink_idle_en = (p % 4) != 2;
            set_plant_config(dt, b0, b1);
            repeat (RANDOM_ITEMS) send_tick(pick_drive());
            wait_idle();
        end
    endtask

    // Closing stretch: no idling on either side, back-to-back transfers.
    task automatic test_quiet_stream();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        set_plant_config(STEP_SIZE_RST, COEFF_CONS_RST, COEFF_SLOP_RST);
        repeat (QUIET_ITEMS) send_tick(pick_drive());
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready with random stall bursts and a requested long park
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        int park_left;
        stall_left      = 0;
        park_left       = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (park_request > 0) begin
                park_left    = park_request;
                park_request = 0;
            end
            if (park_left > 0) begin
                result_ch.ready = 1'b0;
                park_left--;
            end else if (stall_left > 0) begin
                result_ch.ready = 1'b0;
                stall_left--;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                // Start a stall burst that includes this cycle
                result_ch.ready = 1'b0;
                stall_left      = $urandom_range(0, 4);
            end else begin
                result_ch.ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: each transfer against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        tick_report_t want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            if (pending_reports.size() == 0) begin
                flag_mismatch($sformatf("result with nothing pending: y=%0d area=%0d",
                                        result_ch.plant_output,
                                        result_ch.undershoot_total));
            end else begin
                want = pending_reports.pop_front();
                if (result_ch.plant_output !== want.y)
                    flag_mismatch($sformatf("result %0d plant_output %0d, want %0d",
                                            results_seen, result_ch.plant_output, want.y));
                if (result_ch.undershoot_total !== want.area)
                    flag_mismatch($sformatf("result %0d undershoot_total %0d, want %0d",
                                            results_seen, result_ch.undershoot_total,
                                            want.area));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_reports.size());
            $display("** rk4_second_order_plant_step: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        // Hold every input at a known value from time zero
        drive_ch.valid       = 1'b0;
        drive_ch.drive_input = '0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        i_rst_n              = 1'b0;
        reset_plant_model();

        // Assert reset, release on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_register_map();
        test_zero_step();
        test_saturation_extremes();
        test_backpressure();
        test_random_phases();
        test_quiet_stream();

        // Let any stray result show up before the verdict
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d ticks (%0d checked, %0d with negative output) over %0d settings,",
                 ticks_sent, results_seen, neg_ticks, phases_run);
        $display("incl. dt of 0, 1 and full scale, coefficient extremes and a parked output.");
        if (error_count == 0) begin
            $display("** rk4_second_order_plant_step: PASSED **");
        end else begin
            $display("%0d mismatches", error_count);
            $display("** rk4_second_order_plant_step: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
